@@ rtl/tgls_pkg.sv @@
// Shared types and constants for the timed gripper / lift sequencer.
// Used by every module in the rtl folder; depends on nothing else.
package tgls_pkg;

	localparam int CFG_IDX_BITS = 3;
	localparam int TICK_BITS = 16;
	localparam int DUTY_BITS = 7;
	localparam int PHASE_BITS = 4;
	localparam int DRIVE_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_OPEN_TICKS = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLOSE_TICKS = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DOWN_TICKS = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_UP_TICKS = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SETTLE_TICKS = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GAP_TICKS = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GRIPPER_SPEED = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LIFT_SPEED = 3'd7;

	localparam logic [PHASE_BITS-1:0] PH_IDLE = 4'd0;
	localparam logic [PHASE_BITS-1:0] PH_OPEN = 4'd1;
	localparam logic [PHASE_BITS-1:0] PH_SETTLE1 = 4'd2;
	localparam logic [PHASE_BITS-1:0] PH_CLOSE = 4'd3;
	localparam logic [PHASE_BITS-1:0] PH_SETTLE2 = 4'd4;
	localparam logic [PHASE_BITS-1:0] PH_DOWN = 4'd5;
	localparam logic [PHASE_BITS-1:0] PH_SETTLE3 = 4'd6;
	localparam logic [PHASE_BITS-1:0] PH_UP = 4'd7;
	localparam logic [PHASE_BITS-1:0] PH_SETTLE4 = 4'd8;
	localparam logic [PHASE_BITS-1:0] PH_REOPEN = 4'd9;
	localparam logic [PHASE_BITS-1:0] PH_GAP = 4'd10;
	localparam logic [PHASE_BITS-1:0] PH_HOLD = 4'd11;

	localparam logic [DRIVE_BITS-1:0] DRV_BRAKE = 2'd0;
	localparam logic [DRIVE_BITS-1:0] DRV_FWD = 2'd1;
	localparam logic [DRIVE_BITS-1:0] DRV_REV = 2'd2;

	localparam logic [DUTY_BITS-1:0] DUTY_MAX = 7'd100;

	typedef struct packed {
		logic [TICK_BITS-1:0] open_ticks;
		logic [TICK_BITS-1:0] close_ticks;
		logic [TICK_BITS-1:0] down_ticks;
		logic [TICK_BITS-1:0] up_ticks;
		logic [TICK_BITS-1:0] settle_ticks;
		logic [TICK_BITS-1:0] gap_ticks;
		logic [DUTY_BITS-1:0] gripper_speed;
		logic [DUTY_BITS-1:0] lift_speed;
	} cfg_t;

	typedef struct packed {
		logic [DRIVE_BITS-1:0] gripper_drive;
		logic [DUTY_BITS-1:0] gripper_duty;
		logic [DRIVE_BITS-1:0] lift_drive;
		logic [DUTY_BITS-1:0] lift_duty;
		logic status_lamp;
		logic [PHASE_BITS-1:0] phase_now;
		logic stop_event;
		logic run_done;
	} res_t;

endpackage

@@ rtl/timed_gripper_lift_sequencer_core.sv @@
// Top level of the timed gripper / lift sequencer.
// Instantiates tgls_cfg_regs and tgls_seq; depends on tgls_pkg.
//
// Each input transaction is one check-period tick carrying the start and
// emergency-stop levels. Every tick yields exactly one output transaction
// with both motor commands, the status lamp, the current phase and the
// stop and run-done flags.
// A tick is captured in an input register, runs through the sequencer
// logic in one pass and lands in the result register, from which it is
// presented. One tick per cycle is sustained while the receiver does not
// stall; the phase and tick-count registers are updated in the same
// cycle the tick leaves the input register, which is what sets this rate.
// When the receiver stalls, the result register holds its transaction and
// the input register still takes one more tick; in_stall rises only when
// both are full.
// Configuration writes are always ready and must be issued while idle.
// Reset clears the pipeline, returns the sequencer to idle with a zero
// tick count and restores the default phase lengths and speeds.
module timed_gripper_lift_sequencer_core
	import tgls_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic start_level,
	input logic stop_level,
	output logic out_valid,
	input logic out_stall,
	output logic [DRIVE_BITS-1:0] gripper_drive,
	output logic [DUTY_BITS-1:0] gripper_duty,
	output logic [DRIVE_BITS-1:0] lift_drive,
	output logic [DUTY_BITS-1:0] lift_duty,
	output logic status_lamp,
	output logic [PHASE_BITS-1:0] phase_now,
	output logic stop_event,
	output logic run_done,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_BITS-1:0] cfg_index,
	input logic [TICK_BITS-1:0] cfg_data
);

	cfg_t cfg;
	res_t res;
	res_t res_q;
	logic valid_s1;
	logic start_s1;
	logic stop_s1;
	logic out_valid_q;
	logic advance;
	logic step_en;

	assign cfg_ready = 1'b1;
	assign advance = !out_valid_q || !out_stall;
	assign step_en = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	tgls_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cfg_valid && cfg_ready),
		.wr_index(cfg_index),
		.wr_data(cfg_data),
		.cfg(cfg)
	);

	tgls_seq #(
		.COUNT_BITS(COUNT_BITS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(step_en),
		.start_level(start_s1),
		.stop_level(stop_s1),
		.cfg(cfg),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			start_s1 <= start_level;
			stop_s1 <= stop_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign gripper_drive = res_q.gripper_drive;
	assign gripper_duty = res_q.gripper_duty;
	assign lift_drive = res_q.lift_drive;
	assign lift_duty = res_q.lift_duty;
	assign status_lamp = res_q.status_lamp;
	assign phase_now = res_q.phase_now;
	assign stop_event = res_q.stop_event;
	assign run_done = res_q.run_done;

endmodule

@@ rtl/tgls_cfg_regs.sv @@
// Configuration register file of the sequencer.
// Depends on tgls_pkg for the register indexes and the cfg_t struct.
module tgls_cfg_regs
	import tgls_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [CFG_IDX_BITS-1:0] wr_index,
	input logic [TICK_BITS-1:0] wr_data,
	output cfg_t cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_ticks <= 16'd80;
			cfg_q.close_ticks <= 16'd90;
			cfg_q.down_ticks <= 16'd120;
			cfg_q.up_ticks <= 16'd90;
			cfg_q.settle_ticks <= 16'd15;
			cfg_q.gap_ticks <= 16'd25;
			cfg_q.gripper_speed <= 7'd60;
			cfg_q.lift_speed <= 7'd70;
		end else if (wr_en) begin
			case (wr_index)
				CFG_OPEN_TICKS: cfg_q.open_ticks <= wr_data;
				CFG_CLOSE_TICKS: cfg_q.close_ticks <= wr_data;
				CFG_DOWN_TICKS: cfg_q.down_ticks <= wr_data;
				CFG_UP_TICKS: cfg_q.up_ticks <= wr_data;
				CFG_SETTLE_TICKS: cfg_q.settle_ticks <= wr_data;
				CFG_GAP_TICKS: cfg_q.gap_ticks <= wr_data;
				CFG_GRIPPER_SPEED: cfg_q.gripper_speed <= wr_data[DUTY_BITS-1:0];
				CFG_LIFT_SPEED: cfg_q.lift_speed <= wr_data[DUTY_BITS-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/tgls_seq.sv @@
// Phase sequencer: phase, tick counter and start-edge state, plus the
// single-pass logic that turns one tick into one result. Depends on tgls_pkg.
module tgls_seq
	import tgls_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic step_en,
	input logic start_level,
	input logic stop_level,
	input cfg_t cfg,
	output res_t res
);

	localparam int LW = (COUNT_BITS > TICK_BITS) ? COUNT_BITS : TICK_BITS;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [PHASE_BITS-1:0] phase_q;
	logic [COUNT_BITS-1:0] count_q;
	logic prev_start_q;

	logic [10:0] nz;
	logic [PHASE_BITS-1:0] cur0;
	logic [PHASE_BITS-1:0] cur;
	logic [PHASE_BITS-1:0] nxt;
	logic [PHASE_BITS-1:0] phase_d;
	logic [COUNT_BITS-1:0] count_d;
	logic [COUNT_BITS-1:0] cnt_base;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [COUNT_BITS-1:0] cur_len;
	logic [TICK_BITS-1:0] raw_len;
	logic [LW-1:0] raw_wide;
	logic launch;
	logic [DUTY_BITS-1:0] g_duty;
	logic [DUTY_BITS-1:0] l_duty;

	function automatic logic [PHASE_BITS-1:0] seek(input logic [PHASE_BITS-1:0] p,
		input logic [10:0] mask);
		logic [PHASE_BITS-1:0] r;
		r = PH_IDLE;
		for (int k = 10; k >= 1; k--) begin
			if (PHASE_BITS'(k) >= p && mask[k]) begin
				r = PHASE_BITS'(k);
			end
		end
		return r;
	endfunction

	assign nz = {cfg.gap_ticks != '0, cfg.open_ticks != '0, cfg.settle_ticks != '0,
		cfg.up_ticks != '0, cfg.settle_ticks != '0, cfg.down_ticks != '0,
		cfg.settle_ticks != '0, cfg.close_ticks != '0, cfg.settle_ticks != '0,
		cfg.open_ticks != '0, 1'b0};

	assign g_duty = (cfg.gripper_speed > DUTY_MAX) ? DUTY_MAX : cfg.gripper_speed;
	assign l_duty = (cfg.lift_speed > DUTY_MAX) ? DUTY_MAX : cfg.lift_speed;

	assign cur0 = (phase_q > PH_GAP) ? PH_IDLE : phase_q;
	assign launch = (cur0 == PH_IDLE) && start_level && !prev_start_q;
	assign cur = launch ? seek(PH_OPEN, nz) : cur0;

	always_comb begin
		case (cur)
			PH_OPEN, PH_REOPEN: raw_len = cfg.open_ticks;
			PH_CLOSE: raw_len = cfg.close_ticks;
			PH_DOWN: raw_len = cfg.down_ticks;
			PH_UP: raw_len = cfg.up_ticks;
			PH_SETTLE1, PH_SETTLE2, PH_SETTLE3, PH_SETTLE4: raw_len = cfg.settle_ticks;
			PH_GAP: raw_len = cfg.gap_ticks;
			default: raw_len = '0;
		endcase
	end

	assign raw_wide = LW'(raw_len);
	assign cur_len = (raw_wide > LW'(CNT_MAX)) ? CNT_MAX : raw_wide[COUNT_BITS-1:0];
	assign cnt_base = launch ? '0 : count_q;
	assign cnt_inc = cnt_base + COUNT_BITS'(1);
	assign nxt = seek(cur + PHASE_BITS'(1), nz);

	always_comb begin
		res = '0;
		phase_d = PH_IDLE;
		count_d = '0;
		if (stop_level) begin
			phase_d = PH_HOLD;
			res.phase_now = PH_HOLD;
			res.stop_event = (phase_q != PH_HOLD);
		end else begin
			res.phase_now = cur;
			res.status_lamp = (cur >= PH_OPEN) && (cur <= PH_REOPEN);
			res.run_done = launch && (cur == PH_IDLE || cur == PH_GAP);
			case (cur)
				PH_OPEN, PH_REOPEN: begin
					res.gripper_drive = DRV_FWD;
					res.gripper_duty = g_duty;
				end
				PH_CLOSE: begin
					res.gripper_drive = DRV_REV;
					res.gripper_duty = g_duty;
				end
				PH_DOWN: begin
					res.lift_drive = DRV_FWD;
					res.lift_duty = l_duty;
				end
				PH_UP: begin
					res.lift_drive = DRV_REV;
					res.lift_duty = l_duty;
				end
				default: res.gripper_drive = DRV_BRAKE;
			endcase
			if (cur != PH_IDLE) begin
				if (cnt_inc >= cur_len) begin
					phase_d = nxt;
					if (cur <= PH_REOPEN && (nxt == PH_IDLE || nxt == PH_GAP)) begin
						res.run_done = 1'b1;
					end
				end else begin
					phase_d = cur;
					count_d = cnt_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			prev_start_q <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			count_q <= count_d;
			prev_start_q <= start_level;
		end
	end

endmodule
